// ===== rtl/wsid_pkg.sv =====
// ----------------------------------------------------------------------------
// wsid_pkg
// Shared types and constants for the inbound WebSocket deframer.
// ----------------------------------------------------------------------------
package wsid_pkg;

  localparam int unsigned LenW = 23;
  localparam int unsigned PayLenW = 64;

  localparam logic [LenW-1:0] MaxLenReset = 23'h200000;

  localparam logic [1:0] EvPayload = 2'd0;
  localparam logic [1:0] EvEmpty   = 2'd1;
  localparam logic [1:0] EvClose   = 2'd2;
  localparam logic [1:0] EvError   = 2'd3;

  localparam logic [1:0] TypeText   = 2'd0;
  localparam logic [1:0] TypeBinary = 2'd1;
  localparam logic [1:0] TypePing   = 2'd2;
  localparam logic [1:0] TypePong   = 2'd3;

  localparam logic [3:0] OpCont   = 4'h0;
  localparam logic [3:0] OpText   = 4'h1;
  localparam logic [3:0] OpBinary = 4'h2;
  localparam logic [3:0] OpClose  = 4'h8;
  localparam logic [3:0] OpPing   = 4'h9;
  localparam logic [3:0] OpPong   = 4'hA;

  localparam logic [6:0] Len16Code = 7'd126;
  localparam logic [6:0] Len64Code = 7'd127;

  typedef struct packed {
    logic [1:0] ev;
    logic [7:0] data;
    logic [1:0] mtype;
    logic       first;
    logic       last;
  } res_t;

endpackage

// ===== rtl/websocket_inbound_deframer.sv =====
// ----------------------------------------------------------------------------
// websocket_inbound_deframer
// Byte-serial parser for client-to-server WebSocket frames.
// ----------------------------------------------------------------------------
// Slave stream: one received byte per item on s_axis_tdata.
// Master stream: zero or one result item per input byte. tdata carries the
// unmasked payload byte; tuser carries the event code, the message type and
// the first-of-message flag; tlast marks the last item of a complete message.
// Config channel: cfg_data_i sets the maximum frame and message length,
// always ready; write it only while the block is idle.
// Path: each accepted byte passes through the input register, then the
// result register, which drives the master side.
// Throughput: one byte per cycle while m_axis_tready is high, set by the
// combinational header/payload state update between the two registers.
// Reset: parser waits for a frame's first header byte, no fragment is open,
// and the length limit returns to 2097152 bytes.
// Stall: while the result register is held by a low m_axis_tready the input
// register keeps its byte and s_axis_tready drops once it is full.
// After a close frame or a protocol error every later byte is accepted and
// dropped until reset.
// ----------------------------------------------------------------------------
module websocket_inbound_deframer import wsid_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_axis_tvalid,
  output logic            s_axis_tready,
  input  logic [7:0]      s_axis_tdata,   // [7:0] in_byte
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [7:0]      m_axis_tdata,   // [7:0] data_byte
  output logic [7:0]      m_axis_tuser,   // [1:0] event_res, [3:2] message_type,
                                          // [4] first_of_message, [7:5] zero
  output logic            m_axis_tlast,   // last_of_message
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  logic [LenW-1:0] cfg_data_i
);

  logic       in_valid;
  logic [7:0] in_byte;
  logic       take;
  res_t       res;

  assign cfg_ready_o = 1'b1;

  wsid_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .s_byte_i  (s_axis_tdata),
    .valid_o   (in_valid),
    .byte_o    (in_byte),
    .take_i    (take)
  );

  wsid_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid),
    .in_byte_i   (in_byte),
    .take_o      (take),
    .out_valid_o (m_axis_tvalid),
    .out_res_o   (res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = res.data;
  assign m_axis_tuser = {3'b000, res.first, res.mtype, res.ev};
  assign m_axis_tlast = res.last;

endmodule

// ===== rtl/wsid_in_stage.sv =====
// ----------------------------------------------------------------------------
// wsid_in_stage
// Input register for received bytes; refills in the cycle it is drained.
// ----------------------------------------------------------------------------
module wsid_in_stage (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_valid_i,
  output logic       s_ready_o,
  input  logic [7:0] s_byte_i,
  output logic       valid_o,
  output logic [7:0] byte_o,
  input  logic       take_i
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign s_ready_o = !valid_q || take_i;
  assign valid_o   = valid_q;
  assign byte_o    = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_ready_o) begin
      valid_q <= s_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_ready_o && s_valid_i) begin
      byte_q <= s_byte_i;
    end
  end

endmodule

// ===== rtl/wsid_parser.sv =====
// ----------------------------------------------------------------------------
// wsid_parser
// Frame header parser, payload unmasking and result register.
// ----------------------------------------------------------------------------
module wsid_parser import wsid_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [LenW-1:0] cfg_data_i,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  output logic            take_o,
  output logic            out_valid_o,
  output res_t            out_res_o,
  input  logic            out_ready_i
);

  typedef enum logic [2:0] {
    PhHdr0,
    PhHdr1,
    PhExtLen,
    PhMask,
    PhPayload
  } phase_e;

  phase_e             phase_q, phase_d;
  logic [7:0]         hdr_q, hdr_d;
  logic [3:0]         ext_q, ext_d;
  logic [PayLenW-1:0] left_q, left_d;
  logic [31:0]        key_q, key_d;
  logic [1:0]         midx_q, midx_d;
  logic [1:0]         ftype_q, ftype_d;
  logic [LenW-1:0]    ftotal_q, ftotal_d;
  logic               stopped_q, stopped_d;
  logic               masked_q, masked_d;
  logic [1:0]         frtype_q, frtype_d;
  logic               frfirst_q, frfirst_d;
  logic               frlast_q, frlast_d;
  logic [LenW-1:0]    maxlen_q;
  logic               out_valid_q, out_valid_d;
  res_t               res_q, res_d;

  logic               res_vld;
  logic [3:0]         ext_dec;
  logic [6:0]         len7;
  logic               fin;
  logic [3:0]         op;
  logic               len_over;
  logic [LenW:0]      frag_sum;
  logic               ok;
  logic [7:0]         kbyte;
  logic               pay_end;

  assign take_o      = in_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

  always_comb begin
    phase_d   = phase_q;
    hdr_d     = hdr_q;
    ext_d     = ext_q;
    left_d    = left_q;
    key_d     = key_q;
    midx_d    = midx_q;
    ftype_d   = ftype_q;
    ftotal_d  = ftotal_q;
    stopped_d = stopped_q;
    masked_d  = masked_q;
    frtype_d  = frtype_q;
    frfirst_d = frfirst_q;
    frlast_d  = frlast_q;
    res_vld   = 1'b0;
    res_d     = '0;
    ext_dec   = ext_q - 4'd1;
    len7      = in_byte_i[6:0];
    fin       = hdr_q[7];
    op        = hdr_q[3:0];
    len_over  = (|left_q[PayLenW-1:LenW]) || (left_q[LenW-1:0] > maxlen_q);
    frag_sum  = {1'b0, ftotal_q} + {1'b0, left_q[LenW-1:0]};
    ok        = 1'b0;
    pay_end   = (left_q == {{(PayLenW-1){1'b0}}, 1'b1});
    case (midx_q)
      2'd0:    kbyte = key_q[31:24];
      2'd1:    kbyte = key_q[23:16];
      2'd2:    kbyte = key_q[15:8];
      default: kbyte = key_q[7:0];
    endcase

    if (!stopped_q) begin
      case (phase_q)
        PhHdr0: begin
          hdr_d   = in_byte_i;
          phase_d = PhHdr1;
        end
        PhHdr1: begin
          masked_d = in_byte_i[7];
          if (len7 == Len16Code) begin
            left_d  = '0;
            ext_d   = 4'd2;
            phase_d = PhExtLen;
          end else if (len7 == Len64Code) begin
            left_d  = '0;
            ext_d   = 4'd8;
            phase_d = PhExtLen;
          end else begin
            left_d  = {{(PayLenW-7){1'b0}}, len7};
            ext_d   = 4'd4;
            phase_d = PhMask;
          end
        end
        PhExtLen: begin
          left_d = {left_q[PayLenW-9:0], in_byte_i};
          ext_d  = ext_dec;
          if (ext_dec == 4'd0) begin
            ext_d   = 4'd4;
            phase_d = PhMask;
          end
        end
        PhMask: begin
          key_d = {key_q[23:0], in_byte_i};
          ext_d = ext_dec;
          if (ext_dec == 4'd0) begin
            if (!masked_q || len_over) begin
              stopped_d = 1'b1;
              res_vld   = 1'b1;
              res_d.ev  = EvError;
            end else begin
              case (op)
                OpClose: begin
                  stopped_d = 1'b1;
                  res_vld   = 1'b1;
                  res_d.ev  = EvClose;
                end
                OpPing: begin
                  ok        = 1'b1;
                  frtype_d  = TypePing;
                  frfirst_d = 1'b1;
                  frlast_d  = 1'b1;
                end
                OpPong: begin
                  ok        = 1'b1;
                  frtype_d  = TypePong;
                  frfirst_d = 1'b0;
                  frlast_d  = 1'b0;
                end
                OpCont: begin
                  if (ftype_q == 2'd0 || frag_sum > {1'b0, maxlen_q}) begin
                    stopped_d = 1'b1;
                    res_vld   = 1'b1;
                    res_d.ev  = EvError;
                  end else begin
                    ok        = 1'b1;
                    frtype_d  = {1'b0, ~ftype_q[0]};
                    frfirst_d = 1'b0;
                    frlast_d  = fin;
                    if (fin) begin
                      ftype_d  = 2'd0;
                      ftotal_d = '0;
                    end else begin
                      ftotal_d = frag_sum[LenW-1:0];
                    end
                  end
                end
                OpText, OpBinary: begin
                  ok        = 1'b1;
                  frtype_d  = op[1:0] - 2'd1;
                  frfirst_d = 1'b1;
                  frlast_d  = fin;
                  if (!fin) begin
                    ftype_d  = op[1:0];
                    ftotal_d = left_q[LenW-1:0];
                  end
                end
                default: begin
                  stopped_d = 1'b1;
                  res_vld   = 1'b1;
                  res_d.ev  = EvError;
                end
              endcase
              if (ok) begin
                midx_d = 2'd0;
                if (left_q == '0) begin
                  phase_d = PhHdr0;
                  if (frtype_d != TypePong) begin
                    res_vld     = 1'b1;
                    res_d.ev    = EvEmpty;
                    res_d.mtype = frtype_d;
                    res_d.first = frfirst_d;
                    res_d.last  = frlast_d;
                  end
                end else begin
                  phase_d = PhPayload;
                end
              end
            end
          end
        end
        PhPayload: begin
          midx_d    = midx_q + 2'd1;
          left_d    = left_q - {{(PayLenW-1){1'b0}}, 1'b1};
          frfirst_d = 1'b0;
          if (pay_end) begin
            phase_d = PhHdr0;
          end
          if (frtype_q != TypePong) begin
            res_vld     = 1'b1;
            res_d.ev    = EvPayload;
            res_d.data  = in_byte_i ^ kbyte;
            res_d.mtype = frtype_q;
            res_d.first = frfirst_q;
            res_d.last  = pay_end && frlast_q;
          end
        end
        default: begin
          phase_d = PhHdr0;
        end
      endcase
    end

    if (take_o) begin
      out_valid_d = res_vld;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhHdr0;
      hdr_q       <= '0;
      ext_q       <= '0;
      left_q      <= '0;
      key_q       <= '0;
      midx_q      <= '0;
      ftype_q     <= '0;
      ftotal_q    <= '0;
      stopped_q   <= 1'b0;
      masked_q    <= 1'b0;
      frtype_q    <= '0;
      frfirst_q   <= 1'b0;
      frlast_q    <= 1'b0;
      maxlen_q    <= MaxLenReset;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        maxlen_q <= cfg_data_i;
      end
      if (take_o) begin
        phase_q   <= phase_d;
        hdr_q     <= hdr_d;
        ext_q     <= ext_d;
        left_q    <= left_d;
        key_q     <= key_d;
        midx_q    <= midx_d;
        ftype_q   <= ftype_d;
        ftotal_q  <= ftotal_d;
        stopped_q <= stopped_d;
        masked_q  <= masked_d;
        frtype_q  <= frtype_d;
        frfirst_q <= frfirst_d;
        frlast_q  <= frlast_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && res_vld) begin
      res_q <= res_d;
    end
  end

endmodule
